// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// No dependencies; imported by the ALU, the top level and the testbench.
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Stream payload widths
  localparam int IN_DATA_W  = 32;  // operand_value
  localparam int IN_USER_W  = 4;   // action, operator_code
  localparam int OUT_DATA_W = 40;  // top_value, stack_depth, zero pad
  localparam int OUT_USER_W = 2;   // status
  localparam int TOP_W      = 32;
  localparam int DEPTH_W    = 7;

  // Token kinds; code 3 is a no-op
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_OPER  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_RESP
  } ctrl_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

endpackage

// ===== rtl/pse_stack_ram.sv =====
// Stack storage: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the top level.
module pse_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pse_alu.sv =====
// Arithmetic unit: add/sub, shift-add multiply and restoring
// signed divide at one bit per cycle. Depends on pse_pkg.
module pse_alu #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pse_pkg::alu_req_t      req,
  input  logic [VALUE_WIDTH-1:0] lhs,
  input  logic [VALUE_WIDTH-1:0] rhs,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);
  import pse_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(VW);

  alu_state_t     state, state_next;
  logic [CW-1:0]  cnt;
  logic           last;
  logic           neg;
  logic [VW-1:0]  res;   // product accumulator / quotient
  logic [VW-1:0]  opa;   // multiplicand / divisor magnitude
  logic [VW-1:0]  opb;   // multiplier / dividend bits
  logic [VW-1:0]  rem;
  logic [VW-1:0]  rem_sh;
  logic           fits;
  logic [VW-1:0]  lhs_mag, rhs_mag;

  assign last    = (cnt == CW'(VW - 1));
  assign rem_sh  = {rem[VW-2:0], opb[VW-1]};
  assign fits    = (rem_sh >= opa);
  assign lhs_mag = lhs[VW-1] ? (~lhs + VW'(1)) : lhs;
  assign rhs_mag = rhs[VW-1] ? (~rhs + VW'(1)) : rhs;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL:  state_next = A_MUL;
            OP_DIV:  state_next = A_DIV;
            default: state_next = A_DONE;
          endcase
        end
      end
      A_MUL: begin
        if (last) state_next = A_DONE;
      end
      A_DIV: begin
        if (last) state_next = A_DONE;
      end
      A_DONE:  state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done   = (state == A_DONE);
    result = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        cnt <= '0;
        if (req.start) begin
          case (req.op)
            OP_ADD: res <= lhs + rhs;
            OP_SUB: res <= lhs - rhs;
            OP_MUL: begin
              res <= '0;
              opa <= lhs;
              opb <= rhs;
            end
            default: begin
              res <= '0;
              rem <= '0;
              opa <= rhs_mag;
              opb <= lhs_mag;
              neg <= lhs[VW-1] ^ rhs[VW-1];
            end
          endcase
        end
      end
      A_MUL: begin
        cnt <= cnt + CW'(1);
        if (opb[0]) res <= res + opa;
        opa <= {opa[VW-2:0], 1'b0};
        opb <= {1'b0, opb[VW-1:1]};
      end
      A_DIV: begin
        cnt <= cnt + CW'(1);
        opb <= {opb[VW-2:0], 1'b0};
        if (fits) begin
          rem <= rem_sh - opa;
        end else begin
          rem <= rem_sh;
        end
        // final quotient bit lands together with the sign fix
        if (last && neg) begin
          res <= ~{res[VW-2:0], fits} + VW'(1);
        end else begin
          res <= {res[VW-2:0], fits};
        end
      end
      default: ;
    endcase
  end

  // unit must be idle when a request arrives
  assert property (@(posedge clk) disable iff (rst) req.start |-> state == A_IDLE)
    else $error("alu start while busy");

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// Postfix (RPN) integer expression evaluator, one pre-parsed token per transfer.
//
// Input stream (s_axis_*): tdata carries the operand, tuser the token kind
// (push, operator, clear) and the operator code. Output stream (m_axis_*):
// one transfer per token with the top of stack (0 when empty), the depth and
// a status (ok, underflow, overflow, divide by zero). Error tokens leave the
// stack untouched.
//
// Path from accept to result valid: push, clear and error tokens go to the
// response state; operators pass through the execute, wait and response states,
// multiply and divide staying in the wait state while the one-bit-per-cycle
// multiply/divide unit works. One token is in flight at a time; the next one is
// taken once the result is in the output register, so a stalled receiver holds
// one finished result while one more token is worked on, then the input stalls.
//
// The stack lives in a synchronous RAM; the top entry is also held in a
// register so an operator needs only one RAM read (the left operand).
// Reset empties the stack at once; RAM contents are not cleared.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pse_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] operand_value
  input  logic [pse_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [1:0] action, [3:2] operator_code
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pse_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] top_value, [38:32] stack_depth
  output logic [pse_pkg::OUT_USER_W-1:0] m_axis_tuser    // [1:0] status
);
  import pse_pkg::*;

  localparam int VW  = VALUE_WIDTH;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  ctrl_state_t       state, state_next;
  logic [SPW-1:0]    sp;          // entry count
  logic [SPW-1:0]    sp_m2;
  logic [VW-1:0]     top_q;       // copy of entry sp-1
  status_t           status_q;
  op_t               op_q;

  logic              in_acc;
  logic [1:0]        in_action;
  op_t               in_op;
  logic              full;
  logic              few;         // fewer than two entries
  logic              div_zero;
  logic              go_alu;
  logic [VW-1:0]     push_val;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VW-1:0]     mem_wdata;
  logic [VW-1:0]     mem_rdata;

  alu_req_t          alu_req;
  logic              alu_done;
  logic [VW-1:0]     alu_res;

  logic              out_load;
  logic [TOP_W-1:0]  top_ext;
  logic [DEPTH_W-1:0] depth_ext;
  logic [TOP_W-1:0]  out_top;
  logic [DEPTH_W-1:0] out_depth;
  status_t           out_status;

  assign in_action = s_axis_tuser[1:0];
  assign in_op     = op_t'(s_axis_tuser[3:2]);
  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign full      = (sp == SPW'(STACK_DEPTH));
  assign few       = (sp < SPW'(2));
  assign sp_m2     = sp - SPW'(2);
  assign div_zero  = (in_op == OP_DIV) && (top_q == '0);
  assign go_alu    = (in_action == ACT_OPER) && !few && !div_zero;
  assign out_load  = (state == S_RESP) && (!m_axis_tvalid || m_axis_tready);

  // operand: sign-extend from 32 bits, or keep the low VALUE_WIDTH bits
  // top: sign-extend the stored value, or keep its low 32 bits
  generate
    if (VW > TOP_W) begin : g_wide
      assign push_val = {{(VW - TOP_W){s_axis_tdata[TOP_W-1]}}, s_axis_tdata};
      assign top_ext  = top_q[TOP_W-1:0];
    end else if (VW == TOP_W) begin : g_same
      assign push_val = s_axis_tdata;
      assign top_ext  = top_q;
    end else begin : g_narrow
      assign push_val = s_axis_tdata[VW-1:0];
      assign top_ext  = {{(TOP_W - VW){top_q[VW-1]}}, top_q};
    end
    if (SPW >= DEPTH_W) begin : g_dep_trunc
      assign depth_ext = sp[DEPTH_W-1:0];
    end else begin : g_dep_ext
      assign depth_ext = {{(DEPTH_W - SPW){1'b0}}, sp};
    end
  endgenerate

  pse_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (sp_m2[AW-1:0]),
    .rdata (mem_rdata)
  );

  // lhs comes from RAM (read issued at accept), rhs is the cached top
  pse_alu #(
    .VALUE_WIDTH (VW)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .lhs    (mem_rdata),
    .rhs    (top_q),
    .done   (alu_done),
    .result (alu_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = go_alu ? S_EXEC : S_RESP;
        end
      end
      S_EXEC: state_next = S_WAIT;
      S_WAIT: begin
        if (alu_done) state_next = S_RESP;
      end
      S_RESP: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    alu_req.start = (state == S_EXEC);
    alu_req.op    = op_q;
    mem_we        = 1'b0;
    mem_waddr     = sp[AW-1:0];
    mem_wdata     = push_val;
    if (in_acc && (in_action == ACT_PUSH) && !full) begin
      mem_we = 1'b1;
    end else if ((state == S_WAIT) && alu_done) begin
      // result replaces the left operand
      mem_we    = 1'b1;
      mem_waddr = sp_m2[AW-1:0];
      mem_wdata = alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sp            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        case (in_action)
          ACT_PUSH: begin
            if (!full) sp <= sp + SPW'(1);
          end
          ACT_CLEAR: sp <= '0;
          default: ;
        endcase
      end else if ((state == S_WAIT) && alu_done) begin
        sp <= sp - SPW'(1);
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q <= in_op;
      case (in_action)
        ACT_PUSH: begin
          if (full) begin
            status_q <= ST_OVER;
          end else begin
            status_q <= ST_OK;
            top_q    <= push_val;
          end
        end
        ACT_OPER: begin
          if (few) begin
            status_q <= ST_UNDER;
          end else if (div_zero) begin
            status_q <= ST_DIVZERO;
          end else begin
            status_q <= ST_OK;
          end
        end
        default: status_q <= ST_OK;
      endcase
    end else if ((state == S_WAIT) && alu_done) begin
      top_q <= alu_res;
    end
    if (out_load) begin
      out_top    <= (sp == '0) ? '0 : top_ext;
      out_depth  <= depth_ext;
      out_status <= status_q;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - TOP_W - DEPTH_W){1'b0}}, out_depth, out_top};
  assign m_axis_tuser = out_status;

  assert property (@(posedge clk) disable iff (rst) sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer past depth");

  assert property (@(posedge clk) disable iff (rst)
      mem_we |-> (state == S_IDLE || state == S_WAIT))
    else $error("stack write outside push or writeback");

  assert property (@(posedge clk) disable iff (rst) alu_done |-> state == S_WAIT)
    else $error("alu result with no operation pending");

  assert property (@(posedge clk) disable iff (rst) in_acc |=> state != S_IDLE)
    else $error("token accepted without being processed");

  assert property (@(posedge clk) disable iff (rst)
      ((state == S_WAIT) && alu_done) |-> sp >= SPW'(2))
    else $error("operator writeback with fewer than two entries");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for postfix_stack_evaluator: stream driver, result monitor and
// a cycle-free stack predictor that checks every result transfer field by field.
// Depends on rtl/pse_pkg.sv and rtl/postfix_stack_evaluator.sv.
`timescale 1ns / 100ps

module tb;
  import pse_pkg::*;

  localparam int STACK_ENTRIES = STACK_DEPTH_DEF;
  localparam logic [1:0] ACT_NOP = 2'd3;  // unused token kind, no stack change

  localparam int RANDOM_ITEMS  = 1800;
  localparam int DRAIN_CYCLES  = 64;      // quiet tail after all results are in
  localparam int STALL_LIMIT   = 5000;    // cycles with no transfer on either side
  localparam int HOLD_START    = 3000;    // receiver hold-off window, in monitor cycles
  localparam int HOLD_LEN      = 400;
  localparam int RX_FAST_START = 12000;   // receiver always ready here
  localparam int RX_FAST_LEN   = 4000;
  localparam int TX_FAST_FIRST = 400;     // sender offers back to back for these items
  localparam int TX_FAST_LAST  = 700;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] operand;
    op_t         opc;
  } token_t;

  typedef struct {
    logic [TOP_W-1:0]   top;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } stack_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [IN_USER_W-1:0]  in_tuser  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  postfix_stack_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_tvalid),
    .s_axis_tready (in_tready),
    .s_axis_tdata  (in_tdata),   // [31:0] operand_value
    .s_axis_tuser  (in_tuser),   // [1:0] action, [3:2] operator_code
    .m_axis_tvalid (out_tvalid),
    .m_axis_tready (out_tready),
    .m_axis_tdata  (out_tdata),  // [31:0] top_value, [38:32] stack_depth
    .m_axis_tuser  (out_tuser)   // [1:0] status
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stack predictor: mirrors the evaluator one token at a time.
  // ---------------------------------------------------------------------------
  logic [31:0] model_stack [0:STACK_ENTRIES-1];
  int          model_sp = 0;

  function automatic stack_view_t eval_token(token_t t);
    stack_view_t r;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    longint      quo;
    logic        done;
    r.status = ST_OK;
    case (t.action)
      ACT_PUSH: begin
        if (model_sp >= STACK_ENTRIES) begin
          r.status = ST_OVER;
        end else begin
          model_stack[model_sp] = t.operand;
          model_sp++;
        end
      end
      ACT_OPER: begin
        if (model_sp < 2) begin
          r.status = ST_UNDER;
        end else begin
          rhs  = model_stack[model_sp-1];
          lhs  = model_stack[model_sp-2];
          res  = '0;
          done = 1'b1;
          case (t.opc)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == 32'd0) begin
                // divide by zero: both operands stay put
                done     = 1'b0;
                r.status = ST_DIVZERO;
              end else begin
                // 64-bit divide truncates toward zero; MIN / -1 wraps back to MIN
                quo = longint'($signed(lhs)) / longint'($signed(rhs));
                res = quo[31:0];
              end
            end
          endcase
          if (done) begin
            model_sp--;
            model_stack[model_sp-1] = res;
          end
        end
      end
      ACT_CLEAR: model_sp = 0;
      default: ;
    endcase
    r.top   = (model_sp == 0) ? '0 : model_stack[model_sp-1];
    r.depth = model_sp[DEPTH_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. gen_depth only shapes the sequences; it may drift
  // from the real depth (divide by zero), clears pull it back.
  // ---------------------------------------------------------------------------
  token_t      pending_tokens[$];
  stack_view_t expected_views[$];
  int          gen_depth = 0;
  int          mismatch_count = 0;

  function automatic logic [31:0] rand_operand();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 32'($signed($urandom_range(0, 40)) - 20);  // small, hits /0 too
    if (pick < 50) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_token(logic [1:0] action, logic [31:0] operand, op_t opc);
    token_t t;
    t.action  = action;
    t.operand = operand;
    t.opc     = opc;
    pending_tokens.push_back(t);
    case (action)
      ACT_PUSH:  if (gen_depth < STACK_ENTRIES) gen_depth++;
      ACT_OPER:  if (gen_depth >= 2) gen_depth--;
      ACT_CLEAR: gen_depth = 0;
      default: ;
    endcase
  endtask

  task automatic add_push(logic [31:0] operand);
    add_token(ACT_PUSH, operand, op_t'($urandom_range(0, 3)));
  endtask

  task automatic add_oper(op_t opc);
    add_token(ACT_OPER, $urandom, opc);
  endtask

  // well-formed postfix expression with random operands and operators
  task automatic gen_expression();
    int n;
    int live;
    n    = $urandom_range(2, 8);
    live = 0;
    for (int i = 0; i < n; i++) begin
      add_push(rand_operand());
      live++;
      while (live >= 2 && $urandom_range(0, 1) == 1) begin
        add_oper(op_t'($urandom_range(0, 3)));
        live--;
      end
    end
    while (live > 1) begin
      add_oper(op_t'($urandom_range(0, 3)));
      live--;
    end
    if ($urandom_range(0, 1) == 1) add_token(ACT_CLEAR, $urandom, op_t'($urandom_range(0, 3)));
  endtask

  // fill the stack to the top, push past it, fold a few entries, clear
  task automatic gen_fill();
    while (gen_depth < STACK_ENTRIES) add_push(rand_operand());
    repeat ($urandom_range(1, 3)) add_push(rand_operand());
    repeat ($urandom_range(1, 6)) add_oper(op_t'($urandom_range(0, 3)));
    add_token(ACT_CLEAR, $urandom, op_t'($urandom_range(0, 3)));
  endtask

  // random tokens of any kind, underflow and no-op included
  task automatic gen_noise();
    repeat ($urandom_range(1, 5))
      add_token(2'($urandom_range(0, 3)), rand_operand(), op_t'($urandom_range(0, 3)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending tokens, predicts each one as its transfer happens.
  // ---------------------------------------------------------------------------
  token_t drive_tok;
  int     sent_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_views.push_back(eval_token(drive_tok));
      if (!in_tvalid || in_tready) begin
        if (pending_tokens.size() > 0 &&
            ((sent_count >= TX_FAST_FIRST && sent_count < TX_FAST_LAST) ||
             $urandom_range(0, 99) >= 25)) begin
          drive_tok = pending_tokens.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= drive_tok.operand;
          in_tuser  <= {drive_tok.opc, drive_tok.action};
          sent_count++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction.
  // Ready is random, with one long hold-off that backs up the block and one
  // always-ready stretch.
  // ---------------------------------------------------------------------------
  int          rx_cycle = 0;
  stack_view_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_tvalid && out_tready) begin
        if (expected_views.size() == 0) begin
          $error("result transfer with no token outstanding: top_value %0d",
                 $signed(out_tdata[31:0]));
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          if (out_tdata[31:0] !== want.top) begin
            $error("top_value: expected %0d, got %0d", $signed(want.top),
                   $signed(out_tdata[31:0]));
            mismatch_count++;
          end
          if (out_tdata[38:32] !== want.depth) begin
            $error("stack_depth: expected %0d, got %0d", want.depth, out_tdata[38:32]);
            mismatch_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        out_tready <= 1'b0;
      else if (rx_cycle >= RX_FAST_START && rx_cycle < RX_FAST_START + RX_FAST_LEN)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog: no transfer on either side for too long ends the run.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** postfix_stack_evaluator: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int base_items;

  initial begin
    // directed tokens
    add_oper(OP_ADD);                            // underflow on empty stack
    add_token(ACT_NOP, 32'hFFFF_FFFF, OP_DIV);   // no-op on empty stack
    add_push(32'h7FFF_FFFF);
    add_oper(OP_SUB);                            // underflow with one entry
    add_push(32'h0000_0001);
    add_oper(OP_ADD);                            // MAX + 1 wraps to MIN
    add_push(32'hFFFF_FFFF);
    add_oper(OP_DIV);                            // MIN / -1 wraps to MIN
    add_push(32'h0000_0000);                     // literal zero is an operand
    add_oper(OP_DIV);                            // divide by zero, stack kept
    add_oper(OP_SUB);                            // MIN - 0
    add_push(32'hFFFF_FFF9);                     // -7
    add_push(32'h0000_0002);
    add_oper(OP_DIV);                            // -7 / 2 truncates to -3
    add_oper(OP_MUL);                            // MIN * -3
    add_push(32'h8000_0000);
    add_push(32'h7FFF_FFFF);
    add_oper(OP_MUL);
    add_oper(OP_SUB);
    add_token(ACT_NOP, 32'h0000_0000, OP_ADD);   // no-op with entries present
    add_token(ACT_CLEAR, 32'h8000_0000, OP_MUL);
    add_oper(OP_MUL);                            // underflow after clear
    add_push(32'h0000_0003);
    add_push(32'hFFFF_FFFE);
    add_oper(OP_DIV);                            // 3 / -2 truncates to -1

    // random tokens, mostly well-formed expressions
    base_items = pending_tokens.size();
    while (pending_tokens.size() < base_items + RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:79]:  gen_expression();
        [80:84]: gen_fill();
        default: gen_noise();
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // all tokens offered and taken, then all results in, then a quiet tail
    while (pending_tokens.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("** postfix_stack_evaluator: PASSED **");
    else
      $display("** postfix_stack_evaluator: FAILED **");
    $finish;
  end

endmodule
